### rtl/pfba_pkg.sv
// ----------------------------------------------------------------------------
// pfba_pkg
// shared types and constants of the page frame bitmap allocator
// ----------------------------------------------------------------------------
`default_nettype none

package pfba_pkg;

  localparam int PAGE_W  = 15;  // page number width
  localparam int COUNT_W = 16;  // free page count width
  localparam int BIT_W   = 5;   // bit select inside one bitmap word
  localparam int WORD_W  = 32;  // bitmap word width
  localparam int WIDX_W  = PAGE_W - BIT_W;  // word index carried by a page number

  typedef enum logic [1:0] {
    CMD_FREE  = 2'd0,
    CMD_USED  = 2'd1,
    CMD_ALLOC = 2'd2
  } cmd_t;

  // result of the shared word unit
  typedef struct packed {
    logic [WORD_W-1:0] new_word;
    logic              old_bit;
    logic              zero_found;
    logic [BIT_W-1:0]  zero_pos;
  } word_res_t;

endpackage

`default_nettype wire

### rtl/pfba_bitmap_mem.sv
// ----------------------------------------------------------------------------
// pfba_bitmap_mem
// usage bitmap store, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module pfba_bitmap_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [AW-1:0]     waddr,
  input  wire logic [pfba_pkg::WORD_W-1:0] wdata,
  input  wire logic [AW-1:0]     raddr,
  output logic [pfba_pkg::WORD_W-1:0]      rdata
);

  import pfba_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/pfba_word_unit.sv
// ----------------------------------------------------------------------------
// pfba_word_unit
// shared word unit: first free bit search and single bit update
// ----------------------------------------------------------------------------
`default_nettype none

module pfba_word_unit (
  input  wire logic [pfba_pkg::WORD_W-1:0] word,
  input  wire logic [1:0]                  cmd,
  input  wire logic [pfba_pkg::BIT_W-1:0]  bit_sel,
  output pfba_pkg::word_res_t              res
);

  import pfba_pkg::*;

  logic [WORD_W-1:0] avail;
  logic [BIT_W-1:0]  pos;
  logic [BIT_W-1:0]  sel;
  logic              set_val;

  assign avail = ~word;

  // lowest clear bit
  always_comb begin
    pos = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (avail[i]) begin
        pos = BIT_W'(i);
      end
    end
  end

  assign sel     = (cmd == CMD_ALLOC) ? pos : bit_sel;
  assign set_val = (cmd != CMD_FREE);

  always_comb begin
    res.new_word      = word;
    res.new_word[sel] = set_val;
    res.old_bit       = word[sel];
    res.zero_found    = |avail;
    res.zero_pos      = pos;
  end

endmodule

`default_nettype wire

### rtl/page_frame_bitmap_allocator.sv
// ----------------------------------------------------------------------------
// page_frame_bitmap_allocator
// page frame allocator over a one-bit-per-page usage bitmap (1 = used)
// ----------------------------------------------------------------------------
// sequence: mark free/used reads the word (S_MARK_RD), then writes it and answers (S_MARK_WR);
//   unknown command or page beyond the bitmap answers from S_IDLE, with no bitmap read;
//   allocate scans one bitmap word per cycle from word 0 up to a free page or the end.
// throughput: one command at a time; the single memory read port sets the scan rate
// reset: after rst the bitmap is filled with all ones, one word per cycle,
//   and no word is accepted until the fill ends; free count starts at zero
`default_nettype none

module page_frame_bitmap_allocator #(
  parameter int BITMAP_WORDS = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // command stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // page_index[14:0], zero pad
  input  wire logic [1:0]  s_tuser,   // command[1:0]
  // result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata    // allocated_page[14:0], found[15], free_pages[31:16]
);

  import pfba_pkg::*;

  localparam int AW = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MARK_RD,
    S_MARK_WR,
    S_SCAN
  } state_t;

  state_t             state;
  logic [1:0]         cmd;        // command under work
  logic [BIT_W-1:0]   bit_sel;    // bit of the marked page
  logic [AW-1:0]      addr;       // word of the marked page, also clear pointer
  logic [AW:0]        issue_cnt;  // scan reads issued so far
  logic [AW-1:0]      chk_addr;   // word whose read data is on rdata
  logic               chk_valid;
  logic [COUNT_W-1:0] free_total;

  // output register
  logic [PAGE_W-1:0]  out_page;
  logic               out_found;
  logic [COUNT_W-1:0] out_count;

  // input fields
  logic [1:0]         in_cmd;
  logic [PAGE_W-1:0]  in_page;
  logic [WIDX_W-1:0]  in_word;
  logic               in_range;
  logic               in_acc;

  // memory and unit wiring
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [WORD_W-1:0]  mem_wdata;
  logic [AW-1:0]      mem_raddr;
  logic [WORD_W-1:0]  mem_rdata;
  word_res_t          ures;
  logic               scan_hit;
  logic               scan_done;
  logic [AW+BIT_W-1:0] hit_page;

  assign in_cmd   = s_tuser;
  assign in_page  = s_tdata[PAGE_W-1:0];
  assign in_word  = in_page[PAGE_W-1:BIT_W];
  assign in_range = int'(in_word) < BITMAP_WORDS;

  // one command at a time, and only once the previous result word is gone
  assign s_tready = (state == S_IDLE) && !m_tvalid;
  assign in_acc   = s_tvalid && s_tready;

  assign scan_hit  = (state == S_SCAN) && chk_valid && ures.zero_found;
  assign scan_done = (state == S_SCAN) && !chk_valid && (issue_cnt == (AW+1)'(BITMAP_WORDS));
  assign hit_page  = {chk_addr, ures.zero_pos};

  // scan issues reads back to back, other commands read the held word
  assign mem_raddr = (state == S_SCAN) ? issue_cnt[AW-1:0] : addr;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr;
    mem_wdata = ures.new_word;
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = '1;
      end
      S_MARK_WR: begin
        mem_we = 1'b1;
      end
      S_SCAN: begin
        mem_we    = scan_hit;
        mem_waddr = chk_addr;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  pfba_bitmap_mem #(
    .DEPTH (BITMAP_WORDS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // shared unit: searches the scanned word or flips the marked bit
  pfba_word_unit u_unit (
    .word    (mem_rdata),
    .cmd     (cmd),
    .bit_sel (bit_sel),
    .res     (ures)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      addr       <= '0;
      free_total <= '0;
      m_tvalid   <= 1'b0;
      chk_valid  <= 1'b0;
      issue_cnt  <= '0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          // fill every word with all ones, one word per cycle
          if (addr == AW'(BITMAP_WORDS - 1)) begin
            addr  <= '0;
            state <= S_IDLE;
          end else begin
            addr <= addr + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            cmd       <= in_cmd;
            bit_sel   <= in_page[BIT_W-1:0];
            addr      <= AW'(in_word);
            issue_cnt <= '0;
            chk_valid <= 1'b0;
            out_page  <= '0;
            out_found <= 1'b0;
            out_count <= free_total;
            case (in_cmd) inside
              CMD_FREE, CMD_USED: begin
                if (in_range) begin
                  state <= S_MARK_RD;
                end else begin
                  m_tvalid <= 1'b1;  // page beyond the bitmap is ignored
                end
              end
              CMD_ALLOC: begin
                state <= S_SCAN;
              end
              default: begin
                m_tvalid <= 1'b1;  // unknown command changes nothing
              end
            endcase
          end
        end
        S_MARK_RD: begin
          // read of the marked word is in flight
          state <= S_MARK_WR;
        end
        S_MARK_WR: begin
          // count moves only when the bit really changes
          if (cmd == CMD_USED && !ures.old_bit) begin
            free_total <= free_total - 1'b1;
            out_count  <= free_total - 1'b1;
          end else if (cmd == CMD_FREE && ures.old_bit) begin
            free_total <= free_total + 1'b1;
            out_count  <= free_total + 1'b1;
          end else begin
            out_count <= free_total;
          end
          m_tvalid <= 1'b1;
          state    <= S_IDLE;
        end
        S_SCAN: begin
          if (scan_hit) begin
            free_total <= free_total - 1'b1;
            out_count  <= free_total - 1'b1;
            out_page   <= PAGE_W'(hit_page);
            out_found  <= 1'b1;
            m_tvalid   <= 1'b1;
            state      <= S_IDLE;
          end else if (scan_done) begin
            // no free page anywhere
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end else begin
            if (issue_cnt != (AW+1)'(BITMAP_WORDS)) begin
              chk_addr  <= issue_cnt[AW-1:0];
              chk_valid <= 1'b1;
              issue_cnt <= issue_cnt + 1'b1;
            end else begin
              chk_valid <= 1'b0;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign m_tdata = {out_count, out_found, out_page};

endmodule

`default_nettype wire

### verif/pfba_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfba_result_checker
// watches both streams of the page frame allocator, keeps its own copy of
// the usage bitmap and free count, and compares every result word in order
// ----------------------------------------------------------------------------

module pfba_result_checker #(
  parameter int BITMAP_WORDS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,   // page_index[14:0], zero pad
  input  logic [1:0]  s_tuser,   // command[1:0]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,   // allocated_page[14:0], found[15], free_pages[31:16]
  output int          fail_count,
  output int          pending
);
  import pfba_pkg::*;

  // same layout as m_tdata, msb first
  typedef struct packed {
    logic [COUNT_W-1:0] free_pages;
    logic               found;
    logic [PAGE_W-1:0]  page;
  } grant_t;

  logic [WORD_W-1:0]  usage_map [BITMAP_WORDS];
  logic [COUNT_W-1:0] free_cnt;
  grant_t             grant_q [$];
  int                 mismatches = 0;

  function automatic void set_page_bit(int page, logic used);
    int                widx;
    logic [WORD_W-1:0] bit_mask;
    widx = page >> BIT_W;
    if (widx >= BITMAP_WORDS) return;
    bit_mask = '0;
    bit_mask[page & ((1 << BIT_W) - 1)] = 1'b1;
    if (used) begin
      if ((usage_map[widx] & bit_mask) == '0) free_cnt = free_cnt - 1'b1;
      usage_map[widx] = usage_map[widx] | bit_mask;
    end else begin
      if ((usage_map[widx] & bit_mask) != '0) free_cnt = free_cnt + 1'b1;
      usage_map[widx] = usage_map[widx] & ~bit_mask;
    end
  endfunction

  function automatic grant_t apply_cmd(logic [1:0] cmd, logic [PAGE_W-1:0] page);
    grant_t g;
    logic   hit;
    g   = '0;
    hit = 1'b0;
    if (cmd == CMD_FREE) begin
      set_page_bit(int'(page), 1'b0);
    end else if (cmd == CMD_USED) begin
      set_page_bit(int'(page), 1'b1);
    end else if (cmd == CMD_ALLOC) begin
      // lowest free page: first word with a zero, then its lowest zero bit
      for (int w = 0; w < BITMAP_WORDS && !hit; w++) begin
        if (~usage_map[w] != '0) begin
          for (int b = 0; b < WORD_W && !hit; b++) begin
            if (!usage_map[w][b]) begin
              hit    = 1'b1;
              g.page = PAGE_W'(w * WORD_W + b);
              set_page_bit(w * WORD_W + b, 1'b1);
            end
          end
        end
      end
      g.found = hit;
    end
    g.free_pages = free_cnt;
    return g;
  endfunction

  always @(posedge clk) begin
    grant_t got;
    grant_t want;
    if (rst) begin
      for (int w = 0; w < BITMAP_WORDS; w++) usage_map[w] = '1;
      free_cnt = '0;
      grant_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (grant_q.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result word: page %0d found %0d free %0d",
                     got.page, got.found, got.free_pages);
          mismatches++;
        end else begin
          want = grant_q.pop_front();
          if (got.page !== want.page || got.found !== want.found ||
              got.free_pages !== want.free_pages) begin
            if (mismatches < 10)
              $display("mismatch: exp page %0d found %0d free %0d, got page %0d found %0d free %0d",
                       want.page, want.found, want.free_pages,
                       got.page, got.found, got.free_pages);
            mismatches++;
          end
        end
      end
      if (s_tvalid && s_tready) grant_q.push_back(apply_cmd(s_tuser, s_tdata[PAGE_W-1:0]));
    end
    fail_count <= mismatches;
    pending    <= grant_q.size();
  end

endmodule

### verif/page_frame_bitmap_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_frame_bitmap_allocator_tb
// drives mark and allocate commands into the page frame allocator under
// varying idle and stall patterns; a side checker predicts every result word
// ----------------------------------------------------------------------------

module page_frame_bitmap_allocator_tb;
  import pfba_pkg::*;

  localparam int BITMAP_WORDS   = 1024;
  localparam int HOLD_CYCLES    = 400;    // long receiver hold-off
  localparam int WATCHDOG_LIMIT = 20000;  // clear pass + full scan + hold, several times over
  localparam int ITEMS_PER_PHASE = 145;
  localparam int TAIL_CYCLES    = 64;

  // no package member for the spare command code
  localparam logic [1:0] CMD_UNKNOWN = 2'd3;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;   // page_index[14:0], zero pad
  logic [1:0]  s_tuser;   // command[1:0]
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // allocated_page[14:0], found[15], free_pages[31:16]

  int fail_count;
  int pending;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_seq       = 0;
  int stuck_cycles   = 0;

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  page_frame_bitmap_allocator #(.BITMAP_WORDS(BITMAP_WORDS)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  pfba_result_checker #(.BITMAP_WORDS(BITMAP_WORDS)) result_chk (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // watchdog: too long without any word moving on either side
  always @(posedge clk) begin
    if (rst) begin
      stuck_cycles <= 0;
    end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // result side: random stalls, plus a long hold-off whenever hold_seq moves
  initial begin : receiver
    int holds_seen;
    int hold_left;
    m_tready   = 1'b0;
    holds_seen = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk);
      if (hold_seq != holds_seen) begin
        holds_seen = hold_seq;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // offer one command word and wait for its handshake, then maybe go idle
  task automatic send_cmd(input logic [1:0] cmd, input logic [PAGE_W-1:0] page);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {{(16 - PAGE_W){1'b0}}, page};
    do @(posedge clk); while (!s_tready);
    gap = 0;
    while (gap < 8 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // mostly low pages so allocate scans stay short, sometimes anywhere
  function automatic logic [PAGE_W-1:0] pick_page();
    int r;
    r = $urandom_range(99);
    if (r < 80) return PAGE_W'($urandom_range(383));
    else if (r < 92) return PAGE_W'($urandom_range(32767));
    else return PAGE_W'(32767 - $urandom_range(63));
  endfunction

  function automatic logic [1:0] pick_cmd();
    int r;
    r = $urandom_range(99);
    if (r < 40) return CMD_FREE;
    else if (r < 55) return CMD_USED;
    else if (r < 95) return CMD_ALLOC;
    else return CMD_UNKNOWN;
  endfunction

  // pending is updated at the edge, so step past an edge before each look
  task automatic wait_drained();
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input logic long_hold);
    send_idle_pct  <= idle_pct;
    recv_stall_pct <= stall_pct;
    // receiver holds off while the sender keeps offering, so the input backs up
    if (long_hold) hold_seq <= hold_seq + 1;
    for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
      // now and then a free directly followed by an allocate
      if ($urandom_range(9) == 0) begin
        send_cmd(CMD_FREE, pick_page());
        send_cmd(CMD_ALLOC, pick_page());
        i++;
      end else begin
        send_cmd(pick_cmd(), pick_page());
      end
    end
    // sender pauses until every result word has come back
    s_tvalid <= 1'b0;
    wait_drained();
  endtask

  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = CMD_FREE;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: every page starts used, count zero
    send_cmd(CMD_ALLOC, 15'd0);       // nothing free, full scan, not found
    send_cmd(CMD_FREE, 15'd0);
    send_cmd(CMD_FREE, 15'd0);        // redundant free
    send_cmd(CMD_USED, 15'd5);        // redundant mark used
    send_cmd(CMD_FREE, 15'd31);       // top bit of word 0
    send_cmd(CMD_FREE, 15'd32);       // first bit of word 1
    send_cmd(CMD_FREE, 15'h5555);
    send_cmd(CMD_FREE, 15'h2aaa);
    send_cmd(CMD_FREE, 15'h7fff);     // last page of the bitmap
    send_cmd(CMD_UNKNOWN, 15'h7fff);  // spare code changes nothing
    send_cmd(CMD_UNKNOWN, 15'd0);
    send_cmd(CMD_USED, 15'd31);       // free to used drops the count
    send_cmd(CMD_FREE, 15'd31);
    send_cmd(CMD_ALLOC, 15'h7fff);    // page field ignored
    send_cmd(CMD_ALLOC, 15'd0);
    send_cmd(CMD_ALLOC, 15'd0);
    send_cmd(CMD_ALLOC, 15'd0);
    send_cmd(CMD_ALLOC, 15'd0);
    send_cmd(CMD_ALLOC, 15'd0);       // grants the very last page
    send_cmd(CMD_ALLOC, 15'd0);       // bitmap full again
    send_cmd(CMD_FREE, 15'd1000);
    send_cmd(CMD_USED, 15'd1000);
    // sender pauses until every result word has come back
    s_tvalid <= 1'b0;
    @(posedge clk);
    wait_drained();

    run_phase(0, 0, 1'b1);
    run_phase(50, 0, 1'b0);
    run_phase(0, 50, 1'b1);
    run_phase(34, 34, 1'b0);

    s_tvalid <= 1'b0;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
